// File: design/normal_cdf_polynomial_approx_macros.svh
// Assertion macros shared by the design files.
`ifndef NORMAL_CDF_POLYNOMIAL_APPROX_MACROS_SVH
`define NORMAL_CDF_POLYNOMIAL_APPROX_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define NCDF_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define NCDF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/ncdf_pkg.sv
`default_nettype none
package ncdf_pkg;

    localparam int QB     = 30;
    localparam int LQ_W   = 34;
    localparam int DEN_W  = 32;
    localparam int K_W    = 31;
    localparam int Y_W    = 36;
    localparam int N_W    = 6;
    localparam int R_W    = 30;
    localparam int POLY_W = 33;
    localparam int Q_W    = 31;
    localparam int RES_W  = 34;
    localparam int ET     = 12;
    localparam int RM_W   = 35;
    localparam int RM_SH  = 34;
    localparam int PP_W   = 61;
    localparam int MP_W   = 66;
    localparam int PR_W   = 64;
    localparam int DP_W   = 60;

    localparam logic [Q_W-1:0] Q_ONE  = Q_W'(1) << QB;
    localparam logic [Q_W-1:0] Q_HALF = Q_W'(1) << (QB - 1);

    localparam logic [27:0] C_P        = 28'd248723596;
    localparam logic [29:0] C_LN2      = 30'd744261118;
    localparam logic [28:0] C_INVSQRT  = 29'd428361012;

    // Horner coefficients from a5 down to a1, then a zero for the last step.
    localparam logic signed [POLY_W-1:0] C_HORNER [6] = '{
        33'sd1428371292,
        -33'sd1955558716,
        33'sd1912847369,
        -33'sd382857446,
        33'sd342933307,
        33'sd0
    };

    // Series divisors from twelve down to one, with floor(2^34 / j).
    localparam logic [3:0] EXP_DIV [ET] = '{
        4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1
    };
    localparam logic [RM_W-1:0] EXP_RECIP [ET] = '{
        35'd1431655765, 35'd1561806289, 35'd1717986918, 35'd1908874353,
        35'd2147483648, 35'd2454267026, 35'd2863311530, 35'd3435973836,
        35'd4294967296, 35'd5726623061, 35'd8589934592, 35'd17179869184
    };

endpackage
`default_nettype wire

// File: design/ncdf_recip.sv
`default_nettype none
`include "normal_cdf_polynomial_approx_macros.svh"
module ncdf_recip #(
    parameter int SW = 37
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [ncdf_pkg::DEN_W-1:0]   i_den,
    input  logic [SW-1:0]                i_side,
    output logic                         o_vld,
    output logic [ncdf_pkg::K_W-1:0]     o_k,
    output logic [SW-1:0]                o_side
);
    import ncdf_pkg::*;

    // One quotient bit of round(2^60 / den) per stage.
    logic             r_vld  [K_W];
    logic [DEN_W-1:0] r_rem  [K_W];
    logic [DEN_W-1:0] r_den  [K_W];
    logic [K_W-1:0]   r_nl   [K_W];
    logic [K_W-1:0]   r_q    [K_W];
    logic [SW-1:0]    r_side [K_W];

    for (genvar gi = 0; gi < K_W; gi++) begin : g_stage
        logic             v_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [K_W-1:0]   nl_in;
        logic [K_W-1:0]   q_in;
        logic [SW-1:0]    side_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;

        if (gi == 0) begin : g_first
            assign v_in    = i_vld;
            assign rem_in  = DEN_W'(1) << (QB - 1);
            assign den_in  = i_den;
            assign nl_in   = i_den[DEN_W-1:1];
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[gi-1];
            assign rem_in  = r_rem[gi-1];
            assign den_in  = r_den[gi-1];
            assign nl_in   = r_nl[gi-1];
            assign q_in    = r_q[gi-1];
            assign side_in = r_side[gi-1];
        end

        assign trial = {rem_in, nl_in[K_W-1]};
        assign ge    = trial >= {1'b0, den_in};
        assign n_rem = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi] <= 1'b0;
            end else begin
                r_vld[gi] <= v_in;
            end
            r_rem[gi]  <= n_rem;
            r_den[gi]  <= den_in;
            r_nl[gi]   <= nl_in << 1;
            r_q[gi]    <= {q_in[K_W-2:0], ge};
            r_side[gi] <= side_in;
        end
    end

    assign o_vld  = r_vld[K_W-1];
    assign o_k    = r_q[K_W-1];
    assign o_side = r_side[K_W-1];

    `NCDF_ASSERT_IMPLY(a_k_range, i_clk, i_rst_n, o_vld, (o_k <= Q_ONE) && (o_k != '0), "Reciprocal out of range.")

endmodule
`default_nettype wire

// File: design/ncdf_exp.sv
`default_nettype none
`include "normal_cdf_polynomial_approx_macros.svh"
module ncdf_exp #(
    parameter int SW = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [ncdf_pkg::Y_W-1:0]   i_y,
    input  logic [SW-1:0]              i_side,
    output logic                       o_vld,
    output logic [ncdf_pkg::Q_W-1:0]   o_e,
    output logic [SW-1:0]              o_side
);
    import ncdf_pkg::*;

    // Range reduction y = n*ln2 + r, one bit of n per stage.
    logic           r_g_vld  [N_W];
    logic [Y_W-1:0] r_g_y    [N_W];
    logic [N_W-1:0] r_g_n    [N_W];
    logic [SW-1:0]  r_g_side [N_W];

    for (genvar gi = 0; gi < N_W; gi++) begin : g_range
        localparam int B = N_W - 1 - gi;
        logic           v_in;
        logic [Y_W-1:0] y_in;
        logic [N_W-1:0] n_in;
        logic [SW-1:0]  side_in;
        logic [Y_W-1:0] cst;
        logic           ge;

        if (gi == 0) begin : g_first
            assign v_in    = i_vld;
            assign y_in    = i_y;
            assign n_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_g_vld[gi-1];
            assign y_in    = r_g_y[gi-1];
            assign n_in    = r_g_n[gi-1];
            assign side_in = r_g_side[gi-1];
        end

        assign cst = Y_W'(C_LN2) << B;
        assign ge  = y_in >= cst;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_g_vld[gi] <= 1'b0;
            end else begin
                r_g_vld[gi] <= v_in;
            end
            r_g_y[gi]    <= ge ? (y_in - cst) : y_in;
            r_g_n[gi]    <= n_in | (N_W'(ge) << B);
            r_g_side[gi] <= side_in;
        end
    end

    // Horner series for exp(-r), four stages per term.
    logic            r_a_vld [ET], r_b_vld [ET], r_c_vld [ET], r_d_vld [ET];
    logic [R_W-1:0]  r_a_r   [ET], r_b_r   [ET], r_c_r   [ET], r_d_r   [ET];
    logic [N_W-1:0]  r_a_n   [ET], r_b_n   [ET], r_c_n   [ET], r_d_n   [ET];
    logic [SW-1:0]   r_a_sd  [ET], r_b_sd  [ET], r_c_sd  [ET], r_d_sd  [ET];
    logic [PP_W-1:0] r_a_p   [ET];
    logic [Q_W-1:0]  r_b_q   [ET];
    logic [Q_W-1:0]  r_c_q   [ET];
    logic [MP_W-1:0] r_c_m   [ET];
    logic [Q_W-1:0]  r_d_s   [ET];

    for (genvar gi = 0; gi < ET; gi++) begin : g_term
        logic           v_in;
        logic [R_W-1:0] r_in;
        logic [N_W-1:0] n_in;
        logic [SW-1:0]  side_in;
        logic [Q_W-1:0] s_in;
        logic [Q_W-1:0] t0;
        logic [Q_W-1:0] rem;
        logic [Q_W-1:0] t;

        if (gi == 0) begin : g_first
            assign v_in    = r_g_vld[N_W-1];
            assign r_in    = r_g_y[N_W-1][R_W-1:0];
            assign n_in    = r_g_n[N_W-1];
            assign side_in = r_g_side[N_W-1];
            assign s_in    = Q_ONE;
        end else begin : g_next
            assign v_in    = r_d_vld[gi-1];
            assign r_in    = r_d_r[gi-1];
            assign n_in    = r_d_n[gi-1];
            assign side_in = r_d_sd[gi-1];
            assign s_in    = r_d_s[gi-1];
        end

        assign t0  = Q_W'(r_c_m[gi] >> RM_SH);
        assign rem = r_c_q[gi] - Q_W'(t0 * Q_W'(EXP_DIV[gi]));
        assign t   = t0 + Q_W'(rem >= Q_W'(EXP_DIV[gi]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld[gi] <= 1'b0;
                r_b_vld[gi] <= 1'b0;
                r_c_vld[gi] <= 1'b0;
                r_d_vld[gi] <= 1'b0;
            end else begin
                r_a_vld[gi] <= v_in;
                r_b_vld[gi] <= r_a_vld[gi];
                r_c_vld[gi] <= r_b_vld[gi];
                r_d_vld[gi] <= r_c_vld[gi];
            end
            r_a_p[gi]  <= PP_W'(r_in) * PP_W'(s_in);
            r_a_r[gi]  <= r_in;
            r_a_n[gi]  <= n_in;
            r_a_sd[gi] <= side_in;

            r_b_q[gi]  <= Q_W'((r_a_p[gi] + (PP_W'(EXP_DIV[gi]) << (QB - 1))) >> QB);
            r_b_r[gi]  <= r_a_r[gi];
            r_b_n[gi]  <= r_a_n[gi];
            r_b_sd[gi] <= r_a_sd[gi];

            r_c_m[gi]  <= MP_W'(r_b_q[gi]) * MP_W'(EXP_RECIP[gi]);
            r_c_q[gi]  <= r_b_q[gi];
            r_c_r[gi]  <= r_b_r[gi];
            r_c_n[gi]  <= r_b_n[gi];
            r_c_sd[gi] <= r_b_sd[gi];

            r_d_s[gi]  <= Q_ONE - t;
            r_d_r[gi]  <= r_c_r[gi];
            r_d_n[gi]  <= r_c_n[gi];
            r_d_sd[gi] <= r_c_sd[gi];
        end
    end

    // Scale by 2^-n with rounding.
    logic           r_vld;
    logic [Q_W-1:0] r_e;
    logic [SW-1:0]  r_side;
    logic [Q_W-1:0] n_e;
    logic [Q_W-1:0] w_s;
    logic [N_W-1:0] w_n;

    assign w_s = r_d_s[ET-1];
    assign w_n = r_d_n[ET-1];

    always_comb begin
        if (w_n == '0) begin
            n_e = w_s;
        end else if (w_n >= N_W'(62)) begin
            n_e = '0;
        end else begin
            n_e = Q_W'(((w_s >> (w_n - N_W'(1))) + Q_W'(1)) >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= r_d_vld[ET-1];
        end
        r_e    <= n_e;
        r_side <= r_d_sd[ET-1];
    end

    assign o_vld  = r_vld;
    assign o_e    = r_e;
    assign o_side = r_side;

    `NCDF_ASSERT_IMPLY(a_e_range, i_clk, i_rst_n, o_vld, o_e <= Q_ONE, "Exponential above one.")

endmodule
`default_nettype wire

// File: design/ncdf_poly.sv
`default_nettype none
module ncdf_poly #(
    parameter int SW = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [ncdf_pkg::K_W-1:0]            i_k,
    input  logic [SW-1:0]                       i_side,
    output logic                                o_vld,
    output logic signed [ncdf_pkg::POLY_W-1:0]  o_poly,
    output logic [SW-1:0]                       o_side
);
    import ncdf_pkg::*;

    localparam int STEPS = 5;

    logic                     r_m_vld  [STEPS], r_r_vld [STEPS];
    logic [PR_W-1:0]          r_m_prod [STEPS];
    logic                     r_m_neg  [STEPS];
    logic [K_W-1:0]           r_m_k    [STEPS], r_r_k   [STEPS];
    logic [SW-1:0]            r_m_sd   [STEPS], r_r_sd  [STEPS];
    logic signed [POLY_W-1:0] r_r_poly [STEPS];

    for (genvar gi = 0; gi < STEPS; gi++) begin : g_step
        logic                     v_in;
        logic signed [POLY_W-1:0] p_in;
        logic [K_W-1:0]           k_in;
        logic [SW-1:0]            side_in;
        logic [POLY_W-1:0]        pmag;
        logic [POLY_W-1:0]        prnd;
        logic signed [POLY_W-1:0] pval;

        if (gi == 0) begin : g_first
            assign v_in    = i_vld;
            assign p_in    = C_HORNER[0];
            assign k_in    = i_k;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_r_vld[gi-1];
            assign p_in    = r_r_poly[gi-1];
            assign k_in    = r_r_k[gi-1];
            assign side_in = r_r_sd[gi-1];
        end

        assign pmag = (p_in < 0) ? POLY_W'(-p_in) : POLY_W'(p_in);
        assign prnd = POLY_W'((r_m_prod[gi] + PR_W'(Q_HALF)) >> QB);
        assign pval = r_m_neg[gi] ? -$signed(prnd) : $signed(prnd);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_vld[gi] <= 1'b0;
                r_r_vld[gi] <= 1'b0;
            end else begin
                r_m_vld[gi] <= v_in;
                r_r_vld[gi] <= r_m_vld[gi];
            end
            r_m_prod[gi] <= PR_W'(pmag) * PR_W'(k_in);
            r_m_neg[gi]  <= p_in < 0;
            r_m_k[gi]    <= k_in;
            r_m_sd[gi]   <= side_in;

            r_r_poly[gi] <= pval + C_HORNER[gi+1];
            r_r_k[gi]    <= r_m_k[gi];
            r_r_sd[gi]   <= r_m_sd[gi];
        end
    end

    assign o_vld  = r_r_vld[STEPS-1];
    assign o_poly = r_r_poly[STEPS-1];
    assign o_side = r_r_sd[STEPS-1];

endmodule
`default_nettype wire

// File: design/normal_cdf_polynomial_approx.sv
`default_nettype none
`include "normal_cdf_polynomial_approx_macros.svh"
// Standard normal cumulative probability of a fixed-point argument.
// Input: raise start with i_argument (two's complement, FRACTION_BITS fraction
// bits, range -8 to just under 8). busy stays low, so a transaction is taken
// at every clock edge at which start is high, one per cycle without gaps.
// Output: o_valid marks o_probability for one cycle; the value is the
// probability scaled by 2^FRACTION_BITS, from zero up to and including one.
// The pipeline has 104 register stages: the 31 stages of the reciprocal
// divider, the six range reduction, 48 series and one scaling stages of the
// exponential, the ten stages of the polynomial and the front and back ends.
// Results leave in the order that arguments entered, one per argument.
// The receiver takes every result in its strobe cycle and cannot stall
// the pipeline. Reset clears all valid bits; items in flight are dropped.
module normal_cdf_polynomial_approx #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [FRACTION_BITS+3:0]  i_argument,
    output logic                             o_valid,
    output logic [FRACTION_BITS:0]           o_probability
);
    import ncdf_pkg::*;

    localparam int AW = FRACTION_BITS + 4;
    localparam int SH = QB - FRACTION_BITS;
    localparam logic [FRACTION_BITS:0] PROB_MAX = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

    assign busy = 1'b0;

    // Front end: magnitude, scaled argument products, square term.
    logic          r_s1_vld, r_s1_neg;
    logic [AW-1:0] r_s1_mag;
    logic [AW-1:0] n_s1_mag;

    assign n_s1_mag = i_argument[AW-1] ? (~$unsigned(i_argument) + AW'(1))
                                       : $unsigned(i_argument);

    logic [LQ_W-1:0] w_s2_lq;
    logic            r_s2_vld, r_s2_neg;
    logic [61:0]     r_s2_pl;
    logic [59:0]     r_s2_lo2;
    logic [3:0]      r_s2_hi;
    logic [29:0]     r_s2_lo;

    assign w_s2_lq = LQ_W'(r_s1_mag) << SH;

    logic             r_s3_vld, r_s3_neg;
    logic [DEN_W-1:0] r_s3_den;
    logic [Y_W-1:0]   r_s3_y;
    logic [DEN_W-1:0] n_s3_den;
    logic [Y_W-1:0]   n_s3_y;

    assign n_s3_den = DEN_W'((r_s2_pl + 62'(Q_HALF)) >> QB) + DEN_W'(Q_ONE);
    assign n_s3_y   = ((Y_W'(r_s2_hi) * Y_W'(r_s2_hi)) << (QB - 1))
                    + Y_W'(r_s2_hi) * Y_W'(r_s2_lo)
                    + Y_W'((r_s2_lo2 + 60'(Q_ONE)) >> (QB + 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
        r_s1_neg <= i_argument[AW-1];
        r_s1_mag <= n_s1_mag;

        r_s2_neg <= r_s1_neg;
        r_s2_pl  <= 62'(C_P) * 62'(w_s2_lq);
        r_s2_lo2 <= 60'(w_s2_lq[29:0]) * 60'(w_s2_lq[29:0]);
        r_s2_hi  <= w_s2_lq[33:30];
        r_s2_lo  <= w_s2_lq[29:0];

        r_s3_neg <= r_s2_neg;
        r_s3_den <= n_s3_den;
        r_s3_y   <= n_s3_y;
    end

    // Reciprocal, then exponential, then polynomial.
    logic             w_rc_vld;
    logic [K_W-1:0]   w_rc_k;
    logic [Y_W:0]     w_rc_side;

    ncdf_recip #(.SW(Y_W + 1)) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s3_vld),
        .i_den   (r_s3_den),
        .i_side  ({r_s3_y, r_s3_neg}),
        .o_vld   (w_rc_vld),
        .o_k     (w_rc_k),
        .o_side  (w_rc_side)
    );

    logic           w_ex_vld;
    logic [Q_W-1:0] w_ex_e;
    logic [K_W:0]   w_ex_side;

    ncdf_exp #(.SW(K_W + 1)) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_rc_vld),
        .i_y     (w_rc_side[Y_W:1]),
        .i_side  ({w_rc_k, w_rc_side[0]}),
        .o_vld   (w_ex_vld),
        .o_e     (w_ex_e),
        .o_side  (w_ex_side)
    );

    logic                     w_po_vld;
    logic signed [POLY_W-1:0] w_po_poly;
    logic [Q_W:0]             w_po_side;

    ncdf_poly #(.SW(Q_W + 1)) u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_ex_vld),
        .i_k     (w_ex_side[K_W:1]),
        .i_side  ({w_ex_e, w_ex_side[0]}),
        .o_vld   (w_po_vld),
        .o_poly  (w_po_poly),
        .o_side  (w_po_side)
    );

    // Back end: density, tail product, clamp, mirror and output rounding.
    logic                     r_f1_vld, r_f2_vld, r_f3_vld, r_f4_vld, r_f5_vld;
    logic                     r_f1_neg, r_f2_neg, r_f3_neg, r_f4_neg;
    logic signed [POLY_W-1:0] r_f1_poly, r_f2_poly;
    logic [DP_W-1:0]          r_f1_dp;
    logic [Q_W-1:0]           r_f2_dens;
    logic [PR_W-1:0]          r_f3_prod;
    logic                     r_f3_psg;
    logic signed [RES_W-1:0]  r_f4_res;
    logic [FRACTION_BITS:0]   r_f5_prob;

    logic [POLY_W-1:0]        w_f3_mag;
    logic [POLY_W-1:0]        w_f4_rnd;
    logic signed [POLY_W-1:0] w_f4_tail;
    logic signed [RES_W-1:0]  w_one_s;
    logic [Q_W-1:0]           w_f5_cl;
    logic [Q_W-1:0]           w_f5_mir;
    logic [FRACTION_BITS:0]   n_f5_prob;

    assign w_f3_mag  = (r_f2_poly < 0) ? POLY_W'(-r_f2_poly) : POLY_W'(r_f2_poly);
    assign w_f4_rnd  = POLY_W'((r_f3_prod + PR_W'(Q_HALF)) >> QB);
    assign w_f4_tail = r_f3_psg ? -$signed(w_f4_rnd) : $signed(w_f4_rnd);
    assign w_one_s   = $signed({3'b000, Q_ONE});

    always_comb begin
        if (r_f4_res < 0) begin
            w_f5_cl = '0;
        end else if (r_f4_res > w_one_s) begin
            w_f5_cl = Q_ONE;
        end else begin
            w_f5_cl = r_f4_res[Q_W-1:0];
        end
    end

    assign w_f5_mir = r_f4_neg ? (Q_ONE - w_f5_cl) : w_f5_cl;

    if (SH == 0) begin : g_no_round
        assign n_f5_prob = (FRACTION_BITS+1)'(w_f5_mir);
    end else begin : g_round
        assign n_f5_prob = (FRACTION_BITS+1)'(
            ((Q_W+1)'(w_f5_mir) + ((Q_W+1)'(1) << (SH - 1))) >> SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
            r_f4_vld <= 1'b0;
            r_f5_vld <= 1'b0;
        end else begin
            r_f1_vld <= w_po_vld;
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
            r_f4_vld <= r_f3_vld;
            r_f5_vld <= r_f4_vld;
        end
        r_f1_dp   <= DP_W'(C_INVSQRT) * DP_W'(w_po_side[Q_W:1]);
        r_f1_poly <= w_po_poly;
        r_f1_neg  <= w_po_side[0];

        r_f2_dens <= Q_W'((r_f1_dp + DP_W'(Q_HALF)) >> QB);
        r_f2_poly <= r_f1_poly;
        r_f2_neg  <= r_f1_neg;

        r_f3_prod <= PR_W'(w_f3_mag) * PR_W'(r_f2_dens);
        r_f3_psg  <= r_f2_poly < 0;
        r_f3_neg  <= r_f2_neg;

        r_f4_res  <= w_one_s - RES_W'(w_f4_tail);
        r_f4_neg  <= r_f3_neg;

        r_f5_prob <= n_f5_prob;
    end

    assign o_valid       = r_f5_vld;
    assign o_probability = r_f5_prob;

    `NCDF_ASSERT_IMPLY(a_prob_range, i_clk, i_rst_n, o_valid, o_probability <= PROB_MAX, "Probability above one.")
    `NCDF_ASSERT_IMPLY(a_reset_quiet, i_clk, i_rst_n, $rose(i_rst_n), !o_valid, "Result strobe right after reset.")
    `NCDF_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy, "Pipeline refused a transaction.")

endmodule
`default_nettype wire

// File: dv/tb_normal_cdf_polynomial_approx.sv
`timescale 1ns / 100ps

module tb_normal_cdf_polynomial_approx;

    localparam int FB = 16;
    localparam int AW = FB + 4;
    localparam int PW = FB + 1;
    localparam int QF = 30;
    localparam int LATENCY = 104;

    function automatic longint unsigned q30_const(longint unsigned num, longint unsigned den);
        return (num * (64'd1 << QF) + den / 2) / den;
    endfunction

    localparam longint unsigned ONE_Q30 = 64'd1 << QF;
    localparam longint A1 = q30_const(319381530, 1000000000);
    localparam longint A2 = -q30_const(356563782, 1000000000);
    localparam longint A3 = q30_const(1781477937, 1000000000);
    localparam longint A4 = -q30_const(1821255978, 1000000000);
    localparam longint A5 = q30_const(1330274429, 1000000000);
    localparam longint unsigned SLOPE = q30_const(231641900, 1000000000);
    localparam longint unsigned INV_SQRT_2PI = q30_const(64'd3989422804, 64'd10000000000);
    localparam longint unsigned LOG2E_INV = q30_const(64'd6931471806, 64'd10000000000);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [AW-1:0] i_argument = '0;
    logic                 o_valid;
    logic [PW-1:0]        o_probability;

    logic [PW-1:0] probability_queue[$];
    int            error_count = 0;
    int            idle_pct = 0;

    normal_cdf_polynomial_approx #(.FRACTION_BITS(FB)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_argument    (i_argument),
        .o_valid       (o_valid),
        .o_probability (o_probability)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint mul_q30(longint a, longint unsigned b);
        longint unsigned m;
        longint unsigned p;
        m = (a < 0) ? longint'(-a) : longint'(a);
        p = (m * b + (64'd1 << (QF - 1))) >> QF;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned exp_neg_q30(longint unsigned y);
        longint unsigned n;
        longint unsigned r;
        longint unsigned s;
        longint unsigned d;
        longint unsigned t;
        n = y / LOG2E_INV;
        r = y - n * LOG2E_INV;
        s = ONE_Q30;
        for (int j = 12; j >= 1; j--) begin
            d = longint'(j) << QF;
            t = (r * s + d / 2) / d;
            s = ONE_Q30 - t;
        end
        if (n >= 62) return 0;
        if (n == 0) return s;
        return (s + (64'd1 << (n - 1))) >> n;
    endfunction

    function automatic logic [PW-1:0] normal_cdf(logic signed [AW-1:0] arg);
        longint unsigned raw;
        longint unsigned mag;
        longint unsigned lq;
        longint unsigned den;
        longint unsigned k;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned y;
        longint unsigned ur;
        longint poly;
        longint dens;
        longint tail;
        longint res;
        bit neg;
        raw = {{(64-AW){1'b0}}, arg};
        neg = arg[AW-1];
        mag = neg ? ((64'd1 << AW) - raw) : raw;
        lq = mag << (QF - FB);
        den = ONE_Q30 + ((SLOPE * lq + (64'd1 << (QF - 1))) >> QF);
        k = ((64'd1 << (2 * QF)) + den / 2) / den;
        poly = A5;
        poly = mul_q30(poly, k) + A4;
        poly = mul_q30(poly, k) + A3;
        poly = mul_q30(poly, k) + A2;
        poly = mul_q30(poly, k) + A1;
        poly = mul_q30(poly, k);
        hi = lq >> QF;
        lo = lq & (ONE_Q30 - 1);
        y = hi * hi * (64'd1 << (QF - 1)) + hi * lo + ((lo * lo + (64'd1 << QF)) >> (QF + 1));
        dens = mul_q30(longint'(INV_SQRT_2PI), exp_neg_q30(y));
        tail = mul_q30(poly, (dens < 0) ? 64'd0 : longint'(dens));
        res = longint'(ONE_Q30) - tail;
        if (res < 0) res = 0;
        if (res > longint'(ONE_Q30)) res = ONE_Q30;
        if (neg) res = longint'(ONE_Q30) - res;
        ur = res;
        return PW'((ur + (64'd1 << (QF - FB - 1))) >> (QF - FB));
    endfunction

    task automatic report_mismatch(string what, logic [PW-1:0] got, logic [PW-1:0] want);
        $display("ERROR at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (probability_queue.size() == 0) begin
                report_mismatch("unexpected probability", o_probability, '0);
            end else begin
                logic [PW-1:0] want;
                want = probability_queue.pop_front();
                if (o_probability !== want) begin
                    report_mismatch("probability mismatch", o_probability, want);
                end
            end
        end
    end

    // The start line stays high between back-to-back transactions; it is
    // lowered only when a gap follows.
    task automatic send_argument(logic signed [AW-1:0] arg);
        int gap;
        start <= 1'b1;
        i_argument <= arg;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        probability_queue.push_back(normal_cdf(arg));
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            i_argument <= AW'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (probability_queue.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [AW-1:0] random_argument();
        case ($urandom_range(9))
            0, 1, 2, 3: return AW'($urandom);
            4, 5, 6:    return AW'($signed(20'($urandom_range(0, 3 << FB))) *
                                ($urandom_range(1) ? 1 : -1));
            7:          return AW'($urandom_range(0, 255)) - AW'(128);
            default:    return $urandom_range(1) ? AW'(1 << (AW - 1)) + AW'($urandom_range(255))
                                                  : AW'((1 << (AW - 1)) - 1 - $urandom_range(255));
        endcase
    endfunction

    task automatic test_directed();
        logic signed [AW-1:0] args[$];
        idle_pct = 0;
        args = '{0, 1, -1, 2, -2, 20'sh7FFFF, 20'sh80000, 20'sh80001, 20'sh7FFFE,
                 20'sh10000, -20'sh10000, 20'sh08000, -20'sh08000, 20'sh20000,
                 -20'sh20000, 20'sh30000, -20'sh30000, 20'sh50000, -20'sh50000,
                 20'sh55555, 20'shAAAAA, 20'sh0FFFF, 20'shF0000, 20'sh00100};
        foreach (args[i]) send_argument(args[i]);
        wait_drained();
    endtask

    task automatic test_random_phase(int count, int pct);
        idle_pct = pct;
        repeat (count) send_argument(random_argument());
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_pause_until_drained();
        idle_pct = 0;
        repeat (20) send_argument(random_argument());
        wait_drained();
        repeat (20) send_argument(random_argument());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(400, 0);
        test_random_phase(350, 85);
        test_pause_until_drained();
        test_random_phase(450, 12);
        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
